>>> sv/chw_pkg.sv
// chw_pkg: shared types, microcode program and cosine-weight math for the waveshaper
// no dependencies; used by chw_seq and chebyshev_waveshaper
`default_nettype none

package chw_pkg;

	localparam int QF = 30;
	localparam logic [63:0] ONE64 = 64'd1 << QF;
	localparam logic [63:0] RND_Q = 64'd1 << (QF - 1);
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam int LADDER_MAX = 7;

	localparam logic [63:0] TAYLOR_DIV [10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	typedef logic [3:0] pc_t;
	typedef logic [1:0] asel_t;
	typedef logic [2:0] bsel_t;
	typedef logic [1:0] csel_t;
	typedef logic [2:0] dest_t;
	typedef logic [1:0] tab_t;
	typedef logic [1:0] jmp_t;

	localparam asel_t A_X  = 2'd0;
	localparam asel_t A_T1 = 2'd1;
	localparam asel_t A_T2 = 2'd2;

	localparam bsel_t B_X   = 3'd0;
	localparam bsel_t B_T1  = 3'd1;
	localparam bsel_t B_T2  = 3'd2;
	localparam bsel_t B_OMW = 3'd3;
	localparam bsel_t B_W   = 3'd4;

	localparam csel_t C_ZERO = 2'd0;
	localparam csel_t C_ONE  = 2'd1;
	localparam csel_t C_X    = 2'd2;

	localparam dest_t D_NONE   = 3'd0;
	localparam dest_t D_T1     = 3'd1;
	localparam dest_t D_T2     = 3'd2;
	localparam dest_t D_ACC    = 3'd3;
	localparam dest_t D_ACCADD = 3'd4;

	localparam tab_t T_NONE   = 2'd0;
	localparam tab_t T_LO     = 2'd1;
	localparam tab_t T_HI     = 2'd2;
	localparam tab_t T_INTERP = 2'd3;

	localparam jmp_t J_NEXT   = 2'd0;
	localparam jmp_t J_GO     = 2'd1;
	localparam jmp_t J_LADDER = 2'd2;
	localparam jmp_t J_END    = 2'd3;

	localparam pc_t PC_INIT  = 4'd0;
	localparam pc_t PC_TBHI  = 4'd1;
	localparam pc_t PC_WINT  = 4'd2;
	localparam pc_t PC_ODD0  = 4'd3;
	localparam pc_t PC_ODD1  = 4'd4;
	localparam pc_t PC_BUB   = 4'd5;
	localparam pc_t PC_EVEN0 = 4'd6;
	localparam pc_t PC_EVEN1 = 4'd7;
	localparam pc_t PC_XF0   = 4'd8;
	localparam pc_t PC_XF1   = 4'd9;
	localparam pc_t PC_XF2   = 4'd10;
	localparam pc_t PC_XF3   = 4'd11;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		logic  sh29;
		csel_t csel;
		dest_t dest;
		tab_t  tab;
		logic  adv;
		logic  emit;
		jmp_t  jmp;
		pc_t   target;
	} cw_t;

	localparam cw_t CW_NOP = '{
		asel: A_X, bsel: B_X, sh29: 1'b0, csel: C_ZERO, dest: D_NONE,
		tab: T_NONE, adv: 1'b0, emit: 1'b0, jmp: J_NEXT, target: PC_INIT
	};

	function automatic cw_t ucode(input pc_t pc);
		cw_t cw;
		cw = CW_NOP;
		unique case (pc)
			PC_INIT: begin
				cw.sh29 = 1'b1;
				cw.csel = C_ONE;
				cw.dest = D_T2;
				cw.tab  = T_LO;
			end
			PC_TBHI: begin
				cw.tab = T_HI;
			end
			PC_WINT: begin
				cw.tab    = T_INTERP;
				cw.jmp    = J_LADDER;
				cw.target = PC_XF0;
			end
			PC_ODD0: begin
				cw.asel = A_T1;
				cw.bsel = B_T1;
				cw.sh29 = 1'b1;
				cw.csel = C_ONE;
				cw.dest = D_T1;
			end
			PC_ODD1: begin
				cw.asel   = A_T1;
				cw.bsel   = B_T2;
				cw.sh29   = 1'b1;
				cw.csel   = C_X;
				cw.dest   = D_T2;
				cw.adv    = 1'b1;
				cw.jmp    = J_GO;
				cw.target = PC_BUB;
			end
			PC_BUB: begin
				cw.jmp    = J_LADDER;
				cw.target = PC_XF0;
			end
			PC_EVEN0: begin
				cw.asel = A_T2;
				cw.bsel = B_T1;
				cw.sh29 = 1'b1;
				cw.csel = C_X;
				cw.dest = D_T1;
			end
			PC_EVEN1: begin
				cw.asel   = A_T2;
				cw.bsel   = B_T2;
				cw.sh29   = 1'b1;
				cw.csel   = C_ONE;
				cw.dest   = D_T2;
				cw.adv    = 1'b1;
				cw.jmp    = J_GO;
				cw.target = PC_BUB;
			end
			PC_XF0: begin
				cw.asel = A_T1;
				cw.bsel = B_OMW;
				cw.dest = D_ACC;
			end
			PC_XF1: begin
				cw.asel = A_T2;
				cw.bsel = B_W;
				cw.dest = D_ACCADD;
			end
			PC_XF2: begin
				cw.jmp = J_NEXT;
			end
			PC_XF3: begin
				cw.emit = 1'b1;
				cw.jmp  = J_END;
			end
			default: begin
				cw.jmp = J_END;
			end
		endcase
		return cw;
	endfunction

	// raised-cosine weight (1 - cos(theta))/2 in Q.30, theta already reduced to [0, pi/2]
	function automatic logic [30:0] wpoint(input logic [63:0] theta, input logic neg);
		logic [63:0] th2;
		logic [63:0] mag;
		logic signed [63:0] c;
		logic [63:0] wv;
		th2 = (theta * theta + RND_Q) >> QF;
		mag = ONE64;
		c = $signed(ONE64);
		for (int i = 0; i < 10; i++) begin
			mag = (mag * th2 + RND_Q) >> QF;
			mag = mag / TAYLOR_DIV[i];
			if (i[0] == 1'b0)
				c = c - $signed(mag);
			else
				c = c + $signed(mag);
		end
		if (c > $signed(ONE64))
			c = $signed(ONE64);
		if (c < -$signed(ONE64))
			c = -$signed(ONE64);
		if (neg)
			c = -c;
		wv = ONE64 - $unsigned(c);
		return wv[31:1];
	endfunction

endpackage

`default_nettype wire

>>> sv/chw_seq.sv
// chw_seq: microcode sequencer with step counter, ladder bit queue and branch logic
// depends on chw_pkg
`default_nettype none

module chw_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [6:0]        plan_dir,
	input  wire logic [2:0]        plan_len,
	output chw_pkg::cw_t           cw,
	output logic                   run
);

	chw_pkg::pc_t pc_q;
	logic         run_q;
	logic [6:0]   dir_q;
	logic [2:0]   cnt_q;
	chw_pkg::pc_t pc_nxt;

	assign cw  = chw_pkg::ucode(pc_q);
	assign run = run_q;

	always_comb begin
		pc_nxt = pc_q + chw_pkg::pc_t'(1);
		unique case (cw.jmp)
			chw_pkg::J_NEXT: pc_nxt = pc_q + chw_pkg::pc_t'(1);
			chw_pkg::J_GO:   pc_nxt = cw.target;
			chw_pkg::J_LADDER: begin
				if (cnt_q == 3'd0)
					pc_nxt = cw.target;
				else if (dir_q[0])
					pc_nxt = chw_pkg::PC_ODD0;
				else
					pc_nxt = chw_pkg::PC_EVEN0;
			end
			chw_pkg::J_END:  pc_nxt = chw_pkg::PC_INIT;
			default:         pc_nxt = chw_pkg::PC_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= chw_pkg::PC_INIT;
			run_q <= 1'b0;
			dir_q <= '0;
			cnt_q <= '0;
		end else if (load) begin
			pc_q  <= chw_pkg::PC_INIT;
			run_q <= 1'b1;
			dir_q <= plan_dir;
			cnt_q <= plan_len;
		end else if (run_q) begin
			pc_q <= pc_nxt;
			if (cw.jmp == chw_pkg::J_END)
				run_q <= 1'b0;
			if (cw.adv) begin
				dir_q <= dir_q >> 1;
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (pc_q <= chw_pkg::PC_XF3))
		else $error("step counter outside program");

	a_adv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && cw.adv) |-> (cnt_q != 3'd0))
		else $error("ladder advanced with no steps left");

	a_load_init: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (run_q && pc_q == chw_pkg::PC_INIT))
		else $error("request did not restart the program");

endmodule

`default_nettype wire

>>> sv/chebyshev_waveshaper.sv
// chebyshev_waveshaper: top level, fractional-order Chebyshev waveshaper datapath
// depends on chw_pkg and chw_seq
// result: shaped is loaded as done is strobed, after L ladder steps,
//   L = ladder steps (0..7, from the integer order; 7 for orders 128 and up)
// throughput: a new request is accepted only while busy is low; one shared 31x31
//   multiplier with a registered issue/writeback path serves every ladder step
// reset: asynchronous, clears the sequencer and strobe; no table clearing pass
`default_nettype none

module chebyshev_waveshaper #(
	parameter int COS_TABLE_SIZE = 512,
	parameter int MAX_ORDER      = 255,
	parameter int SAMPLE_BITS    = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic [15:0]                   order,
	output logic                               busy,
	output logic                               done,
	output logic signed [SAMPLE_BITS-1:0]      shaped
);

	localparam int HALF  = COS_TABLE_SIZE / 2;
	localparam int KW    = $clog2(HALF + 1);
	localparam int TAB_N = 1 << KW;
	localparam int PW    = KW + 8;
	localparam int MAXQ  = MAX_ORDER * 256;
	localparam logic signed [33:0] ONE34 = 34'sd1073741824;
	localparam logic [61:0] RND29 = 62'd1 << 28;
	localparam logic [61:0] RND30 = 62'd1 << 29;
	localparam logic signed [35:0] LIM_HI = (36'sd1 <<< (SAMPLE_BITS - 1)) - 36'sd1;
	localparam logic signed [35:0] LIM_LO = -LIM_HI - 36'sd1;

	// weight table, built at elaboration
	logic [30:0] wtab [0:TAB_N-1];
	for (genvar g = 0; g < TAB_N; g++) begin : g_wtab
		localparam int KC = (g > HALF) ? HALF : g;
		localparam bit NEG = (2 * KC > HALF);
		localparam int KR = NEG ? (HALF - KC) : KC;
		localparam logic [63:0] THETA = (chw_pkg::PI_Q30 * 64'(KR)) / 64'(HALF);
		assign wtab[g] = chw_pkg::wpoint(THETA, NEG);
	end

	function automatic logic [9:0] ladder_plan(input logic [7:0] n);
		logic [8:0] m;
		logic [6:0] d;
		logic [2:0] l;
		m = {1'b0, n} + 9'd1;
		d = '0;
		l = '0;
		for (int i = 0; i < chw_pkg::LADDER_MAX; i++) begin
			if (m > 9'd2) begin
				d = {d[5:0], m[0]};
				l = l + 3'd1;
				m = 9'((m + 9'd1) >> 1);
			end
		end
		return {l, d};
	endfunction

	logic                 load;
	chw_pkg::cw_t         cw;
	logic                 run;
	logic signed [31:0]   x_in;
	logic [15:0]          ordc;
	logic [9:0]           plan;
	logic [PW-1:0]        pk;

	logic signed [31:0]   x_q;
	logic signed [31:0]   t1_q;
	logic signed [31:0]   t2_q;
	logic [KW-1:0]        k_q;
	logic [7:0]           r_q;
	logic [30:0]          wlo_q;
	logic [30:0]          whi_q;
	logic [30:0]          w_q;
	logic signed [33:0]   acc_q;
	logic [61:0]          prod_s1;
	logic                 neg_s1;
	logic                 sh29_s1;
	chw_pkg::csel_t       csel_s1;
	chw_pkg::dest_t       dest_s1;
	logic                 done_q;
	logic signed [SAMPLE_BITS-1:0] shaped_q;

	logic signed [31:0]   opa;
	logic signed [31:0]   opb;
	logic [30:0]          ma;
	logic [30:0]          mb;
	logic [61:0]          rnd_sum;
	logic [32:0]          rmag;
	logic signed [33:0]   res;
	logic signed [33:0]   cval;
	logic signed [33:0]   vdiff;
	logic signed [31:0]   tsat;
	logic signed [31:0]   wdiff;
	logic signed [40:0]   wprod;
	logic signed [40:0]   wq;
	logic signed [40:0]   wsum;
	logic signed [35:0]   y_out;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	assign load   = start && !run;
	assign busy   = run;
	assign done   = done_q;
	assign shaped = shaped_q;

	if (SAMPLE_BITS <= 31) begin : g_io
		localparam int ISH = 31 - SAMPLE_BITS;
		localparam logic [34:0] ORND = (35'd1 << ISH) >> 1;
		logic [34:0] omag;
		logic [34:0] orm;
		assign x_in = 32'(sample) <<< ISH;
		assign omag = acc_q[33] ? 35'(-acc_q) : 35'(acc_q);
		assign orm  = (omag + ORND) >> ISH;
		assign y_out = acc_q[33] ? -$signed(36'(orm)) : $signed(36'(orm));
	end else begin : g_io
		logic signed [32:0] sx;
		logic [32:0]        smag;
		logic [32:0]        shalf;
		assign sx    = 33'(sample);
		assign smag  = sx[32] ? 33'(-sx) : 33'(sx);
		assign shalf = (smag + 33'd1) >> 1;
		assign x_in  = sx[32] ? -$signed(32'(shalf)) : $signed(32'(shalf));
		assign y_out = 36'(acc_q) <<< 1;
	end

	always_comb begin
		if (y_out > LIM_HI)
			y_sat = SAMPLE_BITS'(LIM_HI);
		else if (y_out < LIM_LO)
			y_sat = SAMPLE_BITS'(LIM_LO);
		else
			y_sat = SAMPLE_BITS'(y_out);
	end

	always_comb begin
		if (order < 16'd256)
			ordc = 16'd256;
		else if (32'(order) > MAXQ)
			ordc = 16'(MAXQ);
		else
			ordc = order;
		plan = ladder_plan(ordc[15:8]);
		pk   = PW'(ordc[7:0]) * PW'(HALF);
	end

	chw_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.plan_dir (plan[6:0]),
		.plan_len (plan[9:7]),
		.cw       (cw),
		.run      (run)
	);

	// multiplier operands
	always_comb begin
		case (cw.asel)
			chw_pkg::A_T1: opa = t1_q;
			chw_pkg::A_T2: opa = t2_q;
			default:       opa = x_q;
		endcase
		case (cw.bsel)
			chw_pkg::B_T1:  opb = t1_q;
			chw_pkg::B_T2:  opb = t2_q;
			chw_pkg::B_OMW: opb = $signed(32'h4000_0000 - {1'b0, w_q});
			chw_pkg::B_W:   opb = $signed({1'b0, w_q});
			default:        opb = x_q;
		endcase
		ma = opa[31] ? 31'(-opa) : opa[30:0];
		mb = opb[31] ? 31'(-opb) : opb[30:0];
	end

	// round, subtract and clamp on writeback
	always_comb begin
		rnd_sum = prod_s1 + (sh29_s1 ? RND29 : RND30);
		rmag    = sh29_s1 ? rnd_sum[61:29] : {1'b0, rnd_sum[61:30]};
		res     = neg_s1 ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		case (csel_s1)
			chw_pkg::C_ONE: cval = ONE34;
			chw_pkg::C_X:   cval = 34'(x_q);
			default:        cval = '0;
		endcase
		vdiff = res - cval;
		if (vdiff > ONE34)
			tsat = 32'sd1073741824;
		else if (vdiff < -ONE34)
			tsat = -32'sd1073741824;
		else
			tsat = vdiff[31:0];
	end

	// weight interpolation, truncating toward zero
	always_comb begin
		wdiff = $signed({1'b0, whi_q}) - $signed({1'b0, wlo_q});
		wprod = wdiff * $signed({1'b0, r_q});
		wq    = wprod[40] ? ((wprod + 41'sd255) >>> 8) : (wprod >>> 8);
		wsum  = $signed(41'(wlo_q)) + wq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_s1 <= chw_pkg::D_NONE;
			done_q  <= 1'b0;
		end else begin
			dest_s1 <= run ? cw.dest : chw_pkg::D_NONE;
			done_q  <= run && cw.emit;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		neg_s1  <= opa[31] ^ opb[31];
		sh29_s1 <= cw.sh29;
		csel_s1 <= cw.csel;
		if (load) begin
			x_q  <= x_in;
			t1_q <= x_in;
			k_q  <= pk[PW-1:8];
			r_q  <= pk[7:0];
		end else begin
			case (dest_s1)
				chw_pkg::D_T1:     t1_q  <= tsat;
				chw_pkg::D_T2:     t2_q  <= tsat;
				chw_pkg::D_ACC:    acc_q <= res;
				chw_pkg::D_ACCADD: acc_q <= acc_q + res;
				default: ;
			endcase
		end
		if (run) begin
			case (cw.tab)
				chw_pkg::T_LO:     wlo_q <= wtab[k_q];
				chw_pkg::T_HI:     whi_q <= wtab[k_q + KW'(1)];
				chw_pkg::T_INTERP: w_q   <= wsum[30:0];
				default: ;
			endcase
		end
		if (run && cw.emit)
			shaped_q <= y_sat;
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but sequencer not running");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobed twice");

endmodule

`default_nettype wire
